### sv/bpa_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Bitmap page allocator package
// Sizes, opcodes, controller states and the bitmap store request type.
// ---------------------------------------------------------------------------
package bpa_pkg;

   localparam int NUM_PAGES  = 4096;
   localparam int WORD_BITS  = 64;
   localparam int WORD_COUNT = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int ADDR_W     = $clog2(WORD_COUNT);
   localparam int PAGE_W     = 12;
   localparam int COUNT_W    = 13;

   localparam logic [COUNT_W-1:0] NUM_PAGES_C = COUNT_W'(NUM_PAGES);
   localparam logic [ADDR_W-1:0]  LAST_WORD   = ADDR_W'(WORD_COUNT - 1);

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [ADDR_W-1:0]    waddr_type;
   typedef logic [BIT_W-1:0]     bitpos_type;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_DEALLOC = 2'd1,
      OP_QUERY   = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_EVAL = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   typedef struct packed {
      logic      rd_en;
      logic      wr_en;
      waddr_type addr;
      word_type  wr_data;
   } store_req_type;

endpackage
`default_nettype wire

### sv/bpa_bitmap_store.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Bitmap store
// One-port word memory with registered read and a valid bit per word;
// a word never written reads as all free.
// ---------------------------------------------------------------------------
module bpa_bitmap_store (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bpa_pkg::store_req_type req,
   output      bpa_pkg::word_type      rd_data
);
   import bpa_pkg::*;

   word_type               words_ff [WORD_COUNT];
   logic [WORD_COUNT-1:0]  valid_ff;
   word_type               rd_data_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         words_ff[req.addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= words_ff[req.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (req.wr_en) begin
            valid_ff[req.addr] <= 1'b1;
         end
         if (req.rd_en) begin
            rd_valid_ff <= valid_ff[req.addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

`ifndef SYNTHESIS
   a_no_rd_wr_same_cycle: assert property (@(posedge clock) disable iff (reset)
      !(req.rd_en && req.wr_en))
      else $error("bitmap store read and write in one cycle");
   a_write_marks_valid: assert property (@(posedge clock) disable iff (reset)
      req.wr_en |=> valid_ff[$past(req.addr)])
      else $error("written word not marked valid");
   a_read_of_unwritten_is_free: assert property (@(posedge clock) disable iff (reset)
      (req.rd_en && !valid_ff[req.addr]) |=> (rd_data == '0))
      else $error("unwritten word not read as free");
`endif

endmodule
`default_nettype wire

### sv/bpa_word_scan.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Word scan
// Finds the lowest free bit of a bitmap word at or above a masked floor and
// forms the word with that bit marked used.
// ---------------------------------------------------------------------------
module bpa_word_scan (
   input  wire bpa_pkg::word_type   word,
   input  wire bpa_pkg::word_type   low_mask,
   output      logic                found,
   output      bpa_pkg::bitpos_type pos,
   output      bpa_pkg::word_type   set_word
);
   import bpa_pkg::*;

   word_type masked;
   word_type first_zero;

   always_comb begin
      masked     = word | low_mask;
      first_zero = (masked + word_type'(1)) & ~masked;
      found      = ~&masked;
      set_word   = word | first_zero;
      pos        = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (first_zero[i]) begin
            pos = pos | BIT_W'(i);
         end
      end
   end

endmodule
`default_nettype wire

### sv/bitmap_page_allocator.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Bitmap page allocator
// Tracks used/free pages in a word bitmap; allocate, deallocate and query.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one transfer per operation (opcode, page_index).
//   rsp_*  : one transfer per operation (ok, page_out, used_count).
//   One operation is in flight at a time. Deallocate and query take one
//   bitmap read each. Allocate reads one bitmap word at a time, each
//   read followed by an evaluate step, starting at the hint word and
//   stopping at the first free bit or after the last word (no wrap).
//   Rejected operations (full, out of range, unused opcode) skip the read.
//   The single-port bitmap memory sets the rate: read, evaluate, write.
//   A result waits in the output register while the next request is
//   taken; a stalled receiver holds the controller only once the next
//   result is ready.
//   Reset frees every page and zeroes the count and the hint;
//   per-word valid bits stand in for a clearing pass.
// ---------------------------------------------------------------------------
module bitmap_page_allocator (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic [1:0]                  req_opcode,
   input  wire logic [bpa_pkg::PAGE_W-1:0]  req_page_index,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic                        rsp_ok,
   output      logic [bpa_pkg::PAGE_W-1:0]  rsp_page_out,
   output      logic [bpa_pkg::COUNT_W-1:0] rsp_used_count
);
   import bpa_pkg::*;

   state_type            state_ff, state_in;
   opcode_type           op_ff, op_in;
   logic [PAGE_W-1:0]    idx_ff, idx_in;
   waddr_type            addr_ff, addr_in;
   logic [COUNT_W-1:0]   used_ff, used_in;
   logic [COUNT_W-1:0]   hint_ff, hint_in;
   logic                 res_ok_ff, res_ok_in;
   logic [PAGE_W-1:0]    res_page_ff, res_page_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_ok_ff;
   logic [PAGE_W-1:0]    rsp_page_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   store_req_type        st_req;
   word_type             st_rd_data;
   word_type             low_mask;
   logic                 scan_found;
   bitpos_type           scan_pos;
   word_type             scan_word;
   logic                 req_xfer;
   logic                 rsp_free;
   logic                 page_bit;
   logic [PAGE_W-1:0]    new_page;

   bpa_bitmap_store u_store (
      .clock   (clock),
      .reset   (reset),
      .req     (st_req),
      .rd_data (st_rd_data)
   );

   bpa_word_scan u_scan (
      .word     (st_rd_data),
      .low_mask (low_mask),
      .found    (scan_found),
      .pos      (scan_pos),
      .set_word (scan_word)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign page_bit  = st_rd_data[idx_ff[BIT_W-1:0]];
   assign new_page  = {addr_ff, scan_pos};
   assign low_mask  = (addr_ff == hint_ff[BIT_W +: ADDR_W])
                      ? ((word_type'(1) << hint_ff[BIT_W-1:0]) - word_type'(1))
                      : '0;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      idx_in      = idx_ff;
      addr_in     = addr_ff;
      used_in     = used_ff;
      hint_in     = hint_ff;
      res_ok_in   = res_ok_ff;
      res_page_in = res_page_ff;
      st_req      = '0;
      st_req.addr = addr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               op_in       = opcode_type'(req_opcode);
               idx_in      = req_page_index;
               res_ok_in   = 1'b0;
               res_page_in = '0;
               state_in    = ST_DONE;
               case (opcode_type'(req_opcode))
                  OP_ALLOC: begin
                     addr_in = hint_ff[BIT_W +: ADDR_W];
                     if (used_ff < NUM_PAGES_C && hint_ff < NUM_PAGES_C) begin
                        state_in = ST_READ;
                     end
                  end
                  OP_DEALLOC, OP_QUERY: begin
                     addr_in = req_page_index[BIT_W +: ADDR_W];
                     if ({1'b0, req_page_index} < NUM_PAGES_C) begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_READ: begin
            st_req.rd_en = 1'b1;
            state_in     = ST_EVAL;
         end
         ST_EVAL: begin
            case (op_ff)
               OP_ALLOC: begin
                  if (scan_found) begin
                     st_req.wr_en   = 1'b1;
                     st_req.wr_data = scan_word;
                     used_in        = used_ff + COUNT_W'(1);
                     hint_in        = {1'b0, new_page} + COUNT_W'(1);
                     res_ok_in      = 1'b1;
                     res_page_in    = new_page;
                     state_in       = ST_DONE;
                  end else if (addr_ff == LAST_WORD) begin
                     state_in = ST_DONE;
                  end else begin
                     addr_in  = addr_ff + waddr_type'(1);
                     state_in = ST_READ;
                  end
               end
               OP_DEALLOC: begin
                  if (page_bit) begin
                     st_req.wr_en   = 1'b1;
                     st_req.wr_data = st_rd_data
                                      & ~(word_type'(1) << idx_ff[BIT_W-1:0]);
                     if (used_ff != '0) begin
                        used_in = used_ff - COUNT_W'(1);
                     end
                     if ({1'b0, idx_ff} < hint_ff) begin
                        hint_in = {1'b0, idx_ff};
                     end
                     res_ok_in = 1'b1;
                  end
                  state_in = ST_DONE;
               end
               OP_QUERY: begin
                  res_ok_in = !page_bit;
                  state_in  = ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = ((state_ff == ST_DONE) && rsp_free)
                         || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         hint_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      addr_ff     <= addr_in;
      res_ok_ff   <= res_ok_in;
      res_page_ff <= res_page_in;
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_ok_ff    <= res_ok_ff;
         rsp_page_ff  <= res_page_ff;
         rsp_count_ff <= used_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_page_out   = rsp_page_ff;
   assign rsp_used_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state not one-hot");
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      used_ff <= NUM_PAGES_C)
      else $error("used page count out of range");
   a_hint_in_range: assert property (@(posedge clock) disable iff (reset)
      hint_ff <= NUM_PAGES_C)
      else $error("search hint out of range");
   a_write_only_in_eval: assert property (@(posedge clock) disable iff (reset)
      st_req.wr_en |-> (state_ff == ST_EVAL))
      else $error("bitmap write outside evaluate state");
   a_transfer_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != ST_IDLE))
      else $error("controller idle after request transfer");
`endif

endmodule
`default_nettype wire
